@@ hdl/mbox_pkg.sv @@
`default_nettype none

package mbox_pkg;

    // Item kinds carried on s_tuser
    typedef enum logic [2:0] {
        FUNC_HOST_RD = 3'd0,
        FUNC_HOST_WR = 3'd1,
        FUNC_MCU_RD  = 3'd2,
        FUNC_MCU_WR  = 3'd3,
        FUNC_TICK    = 3'd4
    } func_t;

    // Host I/O page groups, address bits 4:3
    typedef enum logic [1:0] {
        GRP_SOUND = 2'd0,
        GRP_SYS   = 2'd1,
        GRP_FIRE  = 2'd2,
        GRP_MBOX  = 2'd3
    } host_grp_t;

    // MCU register numbers
    localparam logic [4:0] REG_PORT_A = 5'd0;
    localparam logic [4:0] REG_PORT_B = 5'd1;
    localparam logic [4:0] REG_PORT_C = 5'd2;
    localparam logic [4:0] REG_DDR_A  = 5'd4;
    localparam logic [4:0] REG_DDR_B  = 5'd5;
    localparam logic [4:0] REG_DDR_C  = 5'd6;
    localparam logic [4:0] REG_TCOUNT = 5'd8;
    localparam logic [4:0] REG_TCTRL  = 5'd9;

    localparam logic [7:0] BYTE_IDLE  = 8'hFF;
    localparam logic [7:0] TCTRL_RST  = 8'h7F;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_TICK = 2'd2,
        ST_RESP = 2'd3
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic exec;
        logic tick_apply;
        logic load_out;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic tick_go;
    } stat_t;

endpackage

`default_nettype wire

@@ hdl/mbox_ctrl.sv @@
`default_nettype none

module mbox_ctrl (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire              out_ready,
    input  mbox_pkg::stat_t  stat,
    output mbox_pkg::cmd_t   cmd
);

    mbox_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    // State and output-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mbox_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            mbox_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = mbox_pkg::ST_EXEC;
                end
            end
            mbox_pkg::ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = stat.tick_go ? mbox_pkg::ST_TICK : mbox_pkg::ST_RESP;
            end
            mbox_pkg::ST_TICK: begin
                cmd.tick_apply = 1'b1;
                state_next     = mbox_pkg::ST_RESP;
            end
            mbox_pkg::ST_RESP: begin
                // output slot free or being emptied this cycle
                if (!out_valid_reg || out_ready) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = mbox_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mbox_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    // An accepted item always goes to execution next
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg == mbox_pkg::ST_EXEC))
        else $error("accepted item did not enter execution");

    // A result is never loaded over one that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result overwritten");

    // Timer apply step only follows execution
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mbox_pkg::ST_TICK) |-> ($past(state_reg) == mbox_pkg::ST_EXEC))
        else $error("timer step out of sequence");

endmodule

`default_nettype wire

@@ hdl/mbox_dp.sv @@
`default_nettype none

module mbox_dp (
    input  wire              aclk,
    input  wire              aresetn,
    input  mbox_pkg::cmd_t   cmd,
    output mbox_pkg::stat_t  stat,
    input  wire [2:0]        in_func,
    input  wire [29:0]       in_data,
    output logic [15:0]      out_data
);

    // Latched item
    logic [2:0] func_reg;
    logic [4:0] addr_reg;
    logic [7:0] wdata_reg;
    logic [7:0] paddle_reg;
    logic       start_one_reg, start_two_reg, service_reg, coin_reg, fire_reg;
    logic [3:0] tick_reg;

    // Block state
    logic       host_flag_reg, host_flag_next;
    logic       mcu_flag_reg, mcu_flag_next;
    logic [7:0] h2m_reg, h2m_next;
    logic [7:0] m2h_reg, m2h_next;
    logic [7:0] port_a_reg, port_a_next;
    logic [7:0] port_b_reg, port_b_next;
    logic [7:0] port_c_reg, port_c_next;
    logic [7:0] ddr_a_reg, ddr_a_next;
    logic [7:0] ddr_b_reg, ddr_b_next;
    logic [7:0] ddr_c_reg, ddr_c_next;
    logic [7:0] tcount_reg, tcount_next;
    logic [7:0] tctrl_reg, tctrl_next;
    logic [7:0] prescale_reg, prescale_next;
    logic       held_reg, held_next;
    logic [4:0] ctl_reg, ctl_next;

    // Per-item results and timer intermediates
    logic [7:0] rdata_reg, rdata_next;
    logic       restart_reg, restart_next;
    logic       wake_reg, wake_next;
    logic [8:0] acc_reg, acc_next;
    logic [8:0] steps_reg, steps_next;
    logic [15:0] out_reg;

    mbox_pkg::func_t    func;
    mbox_pkg::host_grp_t grp;
    logic [7:0]         sys_byte;
    logic [8:0]         pre_mask;

    assign func = mbox_pkg::func_t'(func_reg);
    assign grp  = mbox_pkg::host_grp_t'(addr_reg[4:3]);
    assign stat.tick_go = (func == mbox_pkg::FUNC_TICK) && !held_reg;

    // System status byte: buttons active low, coin active high, flags inverted
    assign sys_byte = {~mcu_flag_reg, ~host_flag_reg, 1'b0, coin_reg, 1'b1,
                       ~service_reg, ~start_two_reg, ~start_one_reg};

    assign pre_mask = (9'd1 << tctrl_reg[2:0]) - 9'd1;

    // Input capture
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            func_reg      <= in_func;
            addr_reg      <= in_data[4:0];
            wdata_reg     <= in_data[12:5];
            paddle_reg    <= in_data[20:13];
            start_one_reg <= in_data[21];
            start_two_reg <= in_data[22];
            service_reg   <= in_data[23];
            coin_reg      <= in_data[24];
            fire_reg      <= in_data[25];
            tick_reg      <= in_data[29:26];
        end
    end

    // Item execution
    always_comb begin
        host_flag_next = host_flag_reg;
        mcu_flag_next  = mcu_flag_reg;
        h2m_next       = h2m_reg;
        m2h_next       = m2h_reg;
        port_a_next    = port_a_reg;
        port_b_next    = port_b_reg;
        port_c_next    = port_c_reg;
        ddr_a_next     = ddr_a_reg;
        ddr_b_next     = ddr_b_reg;
        ddr_c_next     = ddr_c_reg;
        tcount_next    = tcount_reg;
        tctrl_next     = tctrl_reg;
        prescale_next  = prescale_reg;
        held_next      = held_reg;
        ctl_next       = ctl_reg;
        rdata_next     = rdata_reg;
        restart_next   = restart_reg;
        wake_next      = wake_reg;
        acc_next       = acc_reg;
        steps_next     = steps_reg;

        if (cmd.exec) begin
            rdata_next   = mbox_pkg::BYTE_IDLE;
            restart_next = 1'b0;
            wake_next    = 1'b0;
            case (func)
                mbox_pkg::FUNC_HOST_RD: begin
                    case (grp)
                        mbox_pkg::GRP_SYS:  rdata_next = addr_reg[2] ? sys_byte
                                                                     : mbox_pkg::BYTE_IDLE;
                        mbox_pkg::GRP_FIRE: rdata_next = {7'h7F, ~fire_reg};
                        mbox_pkg::GRP_MBOX: begin
                            rdata_next    = m2h_reg;
                            mcu_flag_next = 1'b0;
                        end
                        default: rdata_next = mbox_pkg::BYTE_IDLE;
                    endcase
                end
                mbox_pkg::FUNC_HOST_WR: begin
                    case (grp)
                        mbox_pkg::GRP_SYS: begin
                            ctl_next = {wdata_reg[6], wdata_reg[5], wdata_reg[2:0]};
                            // reset line change clears both semaphores
                            if (~wdata_reg[7] != held_reg) begin
                                held_next      = ~wdata_reg[7];
                                host_flag_next = 1'b0;
                                mcu_flag_next  = 1'b0;
                                restart_next   = wdata_reg[7];
                            end
                        end
                        mbox_pkg::GRP_MBOX: begin
                            h2m_next       = wdata_reg;
                            host_flag_next = 1'b1;
                            wake_next      = !held_reg;
                        end
                        default: ;
                    endcase
                end
                mbox_pkg::FUNC_MCU_RD: begin
                    case (addr_reg)
                        mbox_pkg::REG_PORT_A: rdata_next = port_a_reg;
                        mbox_pkg::REG_PORT_B: rdata_next = ctl_reg[2] ? mbox_pkg::BYTE_IDLE
                                                                      : paddle_reg;
                        mbox_pkg::REG_PORT_C: rdata_next = {port_c_reg[7:2], ~mcu_flag_reg,
                                                            host_flag_reg};
                        mbox_pkg::REG_DDR_A:  rdata_next = ddr_a_reg;
                        mbox_pkg::REG_DDR_B:  rdata_next = ddr_b_reg;
                        mbox_pkg::REG_DDR_C:  rdata_next = ddr_c_reg;
                        mbox_pkg::REG_TCOUNT: rdata_next = tcount_reg;
                        mbox_pkg::REG_TCTRL:  rdata_next = tctrl_reg;
                        default:              rdata_next = mbox_pkg::BYTE_IDLE;
                    endcase
                end
                mbox_pkg::FUNC_MCU_WR: begin
                    case (addr_reg)
                        mbox_pkg::REG_PORT_A: port_a_next = wdata_reg;
                        mbox_pkg::REG_PORT_B: port_b_next = wdata_reg;
                        mbox_pkg::REG_PORT_C: begin
                            port_c_next = wdata_reg;
                            // falling bit 2: take host byte into port A
                            if (port_c_reg[2] && !wdata_reg[2]) begin
                                port_a_next    = h2m_reg;
                                host_flag_next = 1'b0;
                            end
                            // falling bit 3: latch port A (as updated above) as reply
                            if (port_c_reg[3] && !wdata_reg[3]) begin
                                m2h_next      = port_a_next;
                                mcu_flag_next = 1'b1;
                            end
                        end
                        mbox_pkg::REG_DDR_A:  ddr_a_next  = wdata_reg;
                        mbox_pkg::REG_DDR_B:  ddr_b_next  = wdata_reg;
                        mbox_pkg::REG_DDR_C:  ddr_c_next  = wdata_reg;
                        mbox_pkg::REG_TCOUNT: tcount_next = wdata_reg;
                        mbox_pkg::REG_TCTRL:  tctrl_next  = wdata_reg;
                        default: ;
                    endcase
                end
                mbox_pkg::FUNC_TICK: begin
                    // prescaler sum and whole periods elapsed
                    acc_next   = {1'b0, prescale_reg} + {5'd0, tick_reg};
                    steps_next = acc_next >> tctrl_reg[2:0];
                end
                default: ;
            endcase
        end

        // Timer update: count down by elapsed periods, flag underflow
        if (cmd.tick_apply) begin
            tcount_next   = tcount_reg - steps_reg[7:0];
            if (steps_reg > {1'b0, tcount_reg}) begin
                tctrl_next = {1'b1, tctrl_reg[6:0]};
            end
            prescale_next = acc_reg[7:0] & pre_mask[7:0];
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            host_flag_reg <= 1'b0;
            mcu_flag_reg  <= 1'b0;
            h2m_reg       <= '0;
            m2h_reg       <= '0;
            port_a_reg    <= mbox_pkg::BYTE_IDLE;
            port_b_reg    <= mbox_pkg::BYTE_IDLE;
            port_c_reg    <= mbox_pkg::BYTE_IDLE;
            ddr_a_reg     <= '0;
            ddr_b_reg     <= '0;
            ddr_c_reg     <= '0;
            tcount_reg    <= mbox_pkg::BYTE_IDLE;
            tctrl_reg     <= mbox_pkg::TCTRL_RST;
            prescale_reg  <= '0;
            held_reg      <= 1'b1;
            ctl_reg       <= '0;
        end else begin
            host_flag_reg <= host_flag_next;
            mcu_flag_reg  <= mcu_flag_next;
            h2m_reg       <= h2m_next;
            m2h_reg       <= m2h_next;
            port_a_reg    <= port_a_next;
            port_b_reg    <= port_b_next;
            port_c_reg    <= port_c_next;
            ddr_a_reg     <= ddr_a_next;
            ddr_b_reg     <= ddr_b_next;
            ddr_c_reg     <= ddr_c_next;
            tcount_reg    <= tcount_next;
            tctrl_reg     <= tctrl_next;
            prescale_reg  <= prescale_next;
            held_reg      <= held_next;
            ctl_reg       <= ctl_next;
        end
    end

    // Per-item working registers
    always_ff @(posedge aclk) begin
        rdata_reg   <= rdata_next;
        restart_reg <= restart_next;
        wake_reg    <= wake_next;
        acc_reg     <= acc_next;
        steps_reg   <= steps_next;
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg <= {1'b0, wake_reg, restart_reg, held_reg, ctl_reg[4], ctl_reg[3],
                        ctl_reg[1], ctl_reg[0], rdata_reg};
        end
    end

    assign out_data = out_reg;

    // Restart pulse only with the reset line released
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !(restart_reg && held_reg))
        else $error("restart reported while MCU held");

    // The timer never moves while the MCU is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.tick_apply) |-> !held_reg)
        else $error("timer advanced in reset");

    // Host write of the mailbox leaves the host semaphore set
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && func == mbox_pkg::FUNC_HOST_WR && grp == mbox_pkg::GRP_MBOX)
        |=> host_flag_reg)
        else $error("host semaphore not set by mailbox write");

endmodule

`default_nettype wire

@@ hdl/host_mcu_mailbox_with_semaphores_unit.sv @@
// Host/MCU mailbox with semaphores. One item is taken at a time: a host or MCU
// access passes through accept, execute and result-load states; a timer tick
// with the MCU running adds a timer-apply state (the prescaler sum is formed in
// the execute state and the count and prescaler are updated in the apply
// state). The result sits in an output register, so a new item is accepted
// while the previous result waits; the next result is loaded once that
// register is free. Item kind travels on s_tuser; every item yields exactly one
// result.
`default_nettype none

module host_mcu_mailbox_with_semaphores_unit (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // [2:0] func
    input  wire [7:0]   s_tuser,
    // [4:0] addr, [12:5] wdata, [20:13] paddle, [21] start_one, [22] start_two,
    // [23] service_btn, [24] coin_one, [25] fire_btn, [29:26] tick_cycles
    input  wire [31:0]  s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // [7:0] rdata, [8] flip_x, [9] flip_y, [10] gfx_bank, [11] pal_bank,
    // [12] mcu_held, [13] mcu_restart, [14] mcu_wake
    output logic [15:0] m_tdata
);

    mbox_pkg::cmd_t  cmd;
    mbox_pkg::stat_t stat;

    mbox_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mbox_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .in_func  (s_tuser[2:0]),
        .in_data  (s_tdata[29:0]),
        .out_data (m_tdata)
    );

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    // MCU register numbers that stand for unmodeled RAM
    localparam logic [4:0] REG_RAM_LO = 5'd3;
    localparam logic [4:0] REG_RAM_HI = 5'd7;
    // Control latch: bit 7 high lets the MCU run
    localparam logic [7:0] CTL_RUN    = 8'h80;
    localparam int         ITEMS_PER_PHASE = 250;
    localparam int         HOLD_CYCLES     = 60;
    localparam int         TAIL_CYCLES     = 16;

    // s_tdata layout, lowest field last
    typedef struct packed {
        logic [1:0] pad;
        logic [3:0] tick_cycles;
        logic       fire_btn;
        logic       coin_one;
        logic       service_btn;
        logic       start_two;
        logic       start_one;
        logic [7:0] paddle;
        logic [7:0] wdata;
        logic [4:0] addr;
    } item_t;

    // m_tdata layout, lowest field last
    typedef struct packed {
        logic       pad;
        logic       mcu_wake;
        logic       mcu_restart;
        logic       mcu_held;
        logic       pal_bank;
        logic       gfx_bank;
        logic       flip_y;
        logic       flip_x;
        logic [7:0] rdata;
    } result_t;

    // Mailbox and MCU shadow state plus the queue of predicted results
    class mailbox_scoreboard;
        logic       host_flag, mcu_flag, held;
        logic [7:0] to_mcu, to_host, tcount, tctrl, prescale;
        logic [7:0] port[3];
        logic [7:0] ddr[3];
        logic [4:0] ctl;  // {pal, gfx, paddle select, flip_y, flip_x}
        result_t    expected_q[$];
        int         mismatches;

        function new();
            host_flag = 1'b0;
            mcu_flag  = 1'b0;
            held      = 1'b1;
            to_mcu    = 8'h00;
            to_host   = 8'h00;
            tcount    = 8'hFF;
            tctrl     = mbox_pkg::TCTRL_RST;
            prescale  = 8'h00;
            ctl       = '0;
            for (int i = 0; i < 3; i++) begin
                port[i] = 8'hFF;
                ddr[i]  = 8'h00;
            end
            mismatches = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Apply one accepted item to the shadow state and queue its result
        function void note_item(logic [2:0] f, item_t it);
            result_t    r;
            logic [7:0] prev;
            logic       want;
            int         acc, div;
            r = '0;
            r.rdata = mbox_pkg::BYTE_IDLE;
            case (f)
                mbox_pkg::FUNC_HOST_RD: begin
                    case (mbox_pkg::host_grp_t'(it.addr[4:3]))
                        mbox_pkg::GRP_SYS: if (it.addr[2]) begin
                            r.rdata = {~mcu_flag, ~host_flag, 1'b0, it.coin_one, 1'b1,
                                       ~it.service_btn, ~it.start_two, ~it.start_one};
                        end
                        mbox_pkg::GRP_FIRE: r.rdata = it.fire_btn ? 8'hFE : 8'hFF;
                        mbox_pkg::GRP_MBOX: begin
                            mcu_flag = 1'b0;
                            r.rdata  = to_host;
                        end
                        default: ;
                    endcase
                end
                mbox_pkg::FUNC_HOST_WR: begin
                    case (mbox_pkg::host_grp_t'(it.addr[4:3]))
                        mbox_pkg::GRP_SYS: begin
                            ctl  = {it.wdata[6], it.wdata[5], it.wdata[2:0]};
                            want = ~it.wdata[7];
                            // only a change of the reset line clears the flags
                            if (want != held) begin
                                held      = want;
                                host_flag = 1'b0;
                                mcu_flag  = 1'b0;
                                if (!want) r.mcu_restart = 1'b1;
                            end
                        end
                        mbox_pkg::GRP_MBOX: begin
                            to_mcu    = it.wdata;
                            host_flag = 1'b1;
                            if (!held) r.mcu_wake = 1'b1;
                        end
                        default: ;
                    endcase
                end
                mbox_pkg::FUNC_MCU_RD: begin
                    case (it.addr)
                        mbox_pkg::REG_PORT_A: r.rdata = port[0];
                        mbox_pkg::REG_PORT_B: r.rdata = ctl[2] ? 8'hFF : it.paddle;
                        mbox_pkg::REG_PORT_C: r.rdata = {port[2][7:2], ~mcu_flag, host_flag};
                        mbox_pkg::REG_DDR_A:  r.rdata = ddr[0];
                        mbox_pkg::REG_DDR_B:  r.rdata = ddr[1];
                        mbox_pkg::REG_DDR_C:  r.rdata = ddr[2];
                        mbox_pkg::REG_TCOUNT: r.rdata = tcount;
                        mbox_pkg::REG_TCTRL:  r.rdata = tctrl;
                        default:              r.rdata = 8'hFF;
                    endcase
                end
                mbox_pkg::FUNC_MCU_WR: begin
                    case (it.addr)
                        mbox_pkg::REG_PORT_A: port[0] = it.wdata;
                        mbox_pkg::REG_PORT_B: port[1] = it.wdata;
                        mbox_pkg::REG_PORT_C: begin
                            prev    = port[2];
                            port[2] = it.wdata;
                            // falling bit 2 takes the host byte, falling bit 3 posts a reply
                            if (prev[2] && !it.wdata[2]) begin
                                port[0]   = to_mcu;
                                host_flag = 1'b0;
                            end
                            if (prev[3] && !it.wdata[3]) begin
                                to_host  = port[0];
                                mcu_flag = 1'b1;
                            end
                        end
                        mbox_pkg::REG_DDR_A:  ddr[0] = it.wdata;
                        mbox_pkg::REG_DDR_B:  ddr[1] = it.wdata;
                        mbox_pkg::REG_DDR_C:  ddr[2] = it.wdata;
                        mbox_pkg::REG_TCOUNT: tcount = it.wdata;
                        mbox_pkg::REG_TCTRL:  tctrl  = it.wdata;
                        default: ;
                    endcase
                end
                mbox_pkg::FUNC_TICK: begin
                    // timer is frozen while the MCU is held in reset
                    if (!held) begin
                        acc = prescale + it.tick_cycles;
                        div = 1 << tctrl[2:0];
                        while (acc >= div) begin
                            acc = acc - div;
                            if (tcount == 8'h00) tctrl[7] = 1'b1;
                            tcount = tcount - 8'd1;
                        end
                        prescale = acc[7:0];
                    end
                end
                default: ;
            endcase
            r.flip_x   = ctl[0];
            r.flip_y   = ctl[1];
            r.gfx_bank = ctl[3];
            r.pal_bank = ctl[4];
            r.mcu_held = held;
            expected_q.push_back(r);
        endfunction

        function void compare(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [15:0] raw);
            result_t got, want;
            got = result_t'(raw);
            if (expected_q.size() == 0) begin
                $error("result %h arrived with nothing expected", raw);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            compare("rdata", want.rdata, got.rdata);
            compare("flip_x", want.flip_x, got.flip_x);
            compare("flip_y", want.flip_y, got.flip_y);
            compare("gfx_bank", want.gfx_bank, got.gfx_bank);
            compare("pal_bank", want.pal_bank, got.pal_bank);
            compare("mcu_held", want.mcu_held, got.mcu_held);
            compare("mcu_restart", want.mcu_restart, got.mcu_restart);
            compare("mcu_wake", want.mcu_wake, got.mcu_wake);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tuser;   // [2:0] func
    logic [31:0] s_tdata;   // addr, wdata, paddle, buttons, tick_cycles
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // rdata, control bits, held, restart, wake

    mailbox_scoreboard sb = new();

    int src_idle;
    int rcv_idle;
    int items_sent;
    int hold_left;
    bit hold_req;

    host_mcu_mailbox_with_semaphores_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic bit chance(int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic item_t random_item();
        item_t it;
        it = item_t'($urandom);
        it.pad = '0;
        return it;
    endfunction

    // Host address in a group; bit 2 picks the system byte within GRP_SYS
    function automatic logic [4:0] haddr(mbox_pkg::host_grp_t g, bit sel);
        return {g, sel, 2'($urandom_range(3))};
    endfunction

    // Offer one item and wait for the handshake; valid stays high afterwards
    task automatic send(input logic [2:0] f, input item_t it);
        while (chance(src_idle)) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {5'b0, f};
        s_tdata  <= it;
        do @(posedge aclk); while (!s_tready);
        sb.note_item(f, it);
    endtask

    task automatic issue(input logic [2:0] f, input logic [4:0] a, input logic [7:0] d,
                         input int cyc = -1);
        item_t it;
        it = random_item();
        it.addr  = a;
        it.wdata = d;
        if (cyc >= 0) it.tick_cycles = cyc[3:0];
        items_sent++;
        send(f, it);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // Result side: random back-pressure, plus one long hold on request
    initial begin
        m_tready  <= 1'b0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !chance(rcv_idle);
            end
        end
    end

    // Check every accepted result
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    initial begin : stimulus
        int         goal, mid;
        bit         paused;
        logic [7:0] pc;
        logic [7:0] d;
        int         pick;
        item_t      it;

        src_idle   = 28;
        rcv_idle   = 79;
        items_sent = 0;
        hold_req   = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= '0;
        s_tdata  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset view, host map corners, held MCU, release, mailbox, timer wrap
        issue(mbox_pkg::FUNC_HOST_RD, haddr(mbox_pkg::GRP_SYS, 1'b1), 8'($urandom));
        issue(mbox_pkg::FUNC_HOST_RD, haddr(mbox_pkg::GRP_SYS, 1'b0), 8'($urandom));
        issue(mbox_pkg::FUNC_HOST_WR, haddr(mbox_pkg::GRP_SOUND, 1'b1), 8'h55);
        issue(mbox_pkg::FUNC_HOST_RD, haddr(mbox_pkg::GRP_SOUND, 1'b0), 8'($urandom));
        issue(mbox_pkg::FUNC_HOST_RD, haddr(mbox_pkg::GRP_FIRE, 1'b1), 8'($urandom));
        issue(mbox_pkg::FUNC_MCU_RD, mbox_pkg::REG_PORT_B, 8'($urandom));
        issue(mbox_pkg::FUNC_MCU_RD, mbox_pkg::REG_PORT_C, 8'($urandom));
        issue(mbox_pkg::FUNC_MCU_RD, REG_RAM_LO, 8'($urandom));
        issue(mbox_pkg::FUNC_TICK, 5'($urandom), 8'($urandom), 15);
        issue(mbox_pkg::FUNC_MCU_RD, mbox_pkg::REG_TCOUNT, 8'($urandom));
        issue(mbox_pkg::FUNC_HOST_WR, haddr(mbox_pkg::GRP_SYS, 1'b0), 8'hE7);
        issue(mbox_pkg::FUNC_HOST_WR, haddr(mbox_pkg::GRP_SYS, 1'b1), 8'hE7);
        issue(mbox_pkg::FUNC_MCU_RD, mbox_pkg::REG_PORT_B, 8'($urandom));
        issue(mbox_pkg::FUNC_HOST_WR, haddr(mbox_pkg::GRP_MBOX, 1'b0), 8'h00);
        issue(mbox_pkg::FUNC_HOST_WR, haddr(mbox_pkg::GRP_MBOX, 1'b1), 8'hFF);
        issue(mbox_pkg::FUNC_MCU_WR, mbox_pkg::REG_PORT_C, 8'hF3);
        issue(mbox_pkg::FUNC_HOST_RD, haddr(mbox_pkg::GRP_SYS, 1'b1), 8'($urandom));
        issue(mbox_pkg::FUNC_HOST_RD, haddr(mbox_pkg::GRP_MBOX, 1'b0), 8'($urandom));
        issue(mbox_pkg::FUNC_MCU_WR, mbox_pkg::REG_TCTRL, 8'h00);
        issue(mbox_pkg::FUNC_MCU_WR, mbox_pkg::REG_TCOUNT, 8'h01);
        issue(mbox_pkg::FUNC_TICK, 5'($urandom), 8'($urandom), 15);
        issue(mbox_pkg::FUNC_TICK, 5'($urandom), 8'($urandom), 0);
        issue(mbox_pkg::FUNC_MCU_RD, mbox_pkg::REG_TCTRL, 8'($urandom));
        issue(mbox_pkg::FUNC_TICK + 3'($urandom_range(3, 1)), 5'($urandom), 8'($urandom));
        issue(mbox_pkg::FUNC_HOST_WR, haddr(mbox_pkg::GRP_SYS, 1'b0), 8'h18);
        issue(mbox_pkg::FUNC_MCU_WR, mbox_pkg::REG_DDR_A, 8'hA5);
        issue(mbox_pkg::FUNC_MCU_WR, REG_RAM_HI, 8'h00);
        issue(mbox_pkg::FUNC_MCU_RD, mbox_pkg::REG_DDR_A, 8'($urandom));
        issue(mbox_pkg::FUNC_HOST_WR, haddr(mbox_pkg::GRP_SYS, 1'b1), CTL_RUN);

        // Random: three idle profiles, each with one drain pause
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin src_idle = 28; rcv_idle = 79; end
                1: begin src_idle = 79; rcv_idle = 28; end
                default: begin src_idle = 0; rcv_idle = 0; end
            endcase
            goal   = items_sent + ITEMS_PER_PHASE;
            mid    = items_sent + ITEMS_PER_PHASE / 2;
            paused = 1'b0;
            while (items_sent < goal) begin
                if (!paused && items_sent >= mid) begin
                    wait_drained();
                    paused = 1'b1;
                    // long output hold while items keep coming
                    if (ph == 2) hold_req = 1'b1;
                end
                pick = $urandom_range(99);
                if (pick < 35) begin
                    // mailbox round trip, steps dropped now and then
                    pc = 8'($urandom) | 8'h0C;
                    if (chance(92))
                        issue(mbox_pkg::FUNC_HOST_WR, haddr(mbox_pkg::GRP_MBOX, chance(50)),
                              8'($urandom));
                    if (chance(50))
                        issue(mbox_pkg::FUNC_HOST_RD, haddr(mbox_pkg::GRP_SYS, 1'b1),
                              8'($urandom));
                    if (chance(50))
                        issue(mbox_pkg::FUNC_MCU_RD, mbox_pkg::REG_PORT_C, 8'($urandom));
                    if (chance(90)) issue(mbox_pkg::FUNC_MCU_WR, mbox_pkg::REG_PORT_C, pc);
                    pc[2] = 1'b0;
                    if (chance(92)) issue(mbox_pkg::FUNC_MCU_WR, mbox_pkg::REG_PORT_C, pc);
                    if (chance(70))
                        issue(mbox_pkg::FUNC_MCU_RD, mbox_pkg::REG_PORT_A, 8'($urandom));
                    if (chance(85))
                        issue(mbox_pkg::FUNC_MCU_WR, mbox_pkg::REG_PORT_A, 8'($urandom));
                    pc[3] = 1'b0;
                    if (chance(92)) issue(mbox_pkg::FUNC_MCU_WR, mbox_pkg::REG_PORT_C, pc);
                    if (chance(50))
                        issue(mbox_pkg::FUNC_HOST_RD, haddr(mbox_pkg::GRP_SYS, 1'b1),
                              8'($urandom));
                    if (chance(92))
                        issue(mbox_pkg::FUNC_HOST_RD, haddr(mbox_pkg::GRP_MBOX, chance(50)),
                              8'($urandom));
                end else if (pick < 55) begin
                    // timer: short prescale mostly, count near zero in half of its writes
                    d = chance(25) ? 8'($urandom)
                                   : {1'($urandom), 4'($urandom), 3'($urandom_range(3))};
                    issue(mbox_pkg::FUNC_MCU_WR, mbox_pkg::REG_TCTRL, d);
                    if (chance(60))
                        issue(mbox_pkg::FUNC_MCU_WR, mbox_pkg::REG_TCOUNT,
                              chance(50) ? 8'($urandom_range(3)) : 8'($urandom));
                    repeat ($urandom_range(6, 1))
                        issue(mbox_pkg::FUNC_TICK, 5'($urandom), 8'($urandom));
                    issue(mbox_pkg::FUNC_MCU_RD, mbox_pkg::REG_TCOUNT, 8'($urandom));
                    issue(mbox_pkg::FUNC_MCU_RD, mbox_pkg::REG_TCTRL, 8'($urandom));
                end else if (pick < 65) begin
                    // control latch, MCU left running most of the time
                    d = 8'($urandom);
                    d[7] = chance(80);
                    issue(mbox_pkg::FUNC_HOST_WR, haddr(mbox_pkg::GRP_SYS, chance(50)), d);
                end else if (pick < 85) begin
                    // plain register traffic on either side
                    case ($urandom_range(3))
                        0: issue(mbox_pkg::FUNC_MCU_RD, 5'($urandom_range(9)), 8'($urandom));
                        1: issue(mbox_pkg::FUNC_MCU_WR, 5'($urandom_range(9)), 8'($urandom));
                        2: issue(mbox_pkg::FUNC_HOST_RD, 5'($urandom), 8'($urandom));
                        default: issue(mbox_pkg::FUNC_MCU_RD, mbox_pkg::REG_PORT_B,
                                       8'($urandom));
                    endcase
                end else begin
                    // noise: any code, any address
                    it = random_item();
                    items_sent++;
                    send(3'($urandom), it);
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
